// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the filter RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/fiir_pkg.sv -----
// Shared constants, register codes, sequencer states and control struct
// for the fixed point IIR filter. No dependencies.
`timescale 1ns / 1ps

package fiir_pkg;

   // Filter geometry; SCALE must be a power of two
   localparam int TAPS        = 2;
   localparam int HIST        = TAPS - 1;
   localparam int TAP_W       = $clog2(TAPS);
   localparam int SCALE       = 65536;
   localparam int SCALE_SHIFT = $clog2(SCALE);

   // Field widths
   localparam int SAMPLE_W    = 32;
   localparam int NUM_COEF_W  = 16;
   localparam int FB_COEF_W   = 19;
   localparam int GAIN_W      = 17;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 19;
   localparam int HALF_W      = 16;

   // Shared multiplier and accumulator widths
   localparam int MUL_A_W     = 33;
   localparam int MUL_B_W     = 19;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;
   localparam int ACC_W       = 64;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_NUM_COEF_0 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_NUM_COEF_1 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_NUM_COEF_2 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_FB_COEF_1  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_FB_COEF_2  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_NUM_GAIN   = 3'd5;

   // Register reset values
   localparam logic signed [NUM_COEF_W-1:0] RST_NUM_COEF_0 = 16'sd1;
   localparam logic signed [NUM_COEF_W-1:0] RST_NUM_COEF_1 = 16'sd1;
   localparam logic signed [NUM_COEF_W-1:0] RST_NUM_COEF_2 = 16'sd0;
   localparam logic signed [FB_COEF_W-1:0]  RST_FB_COEF_1  = -19'sd65330;
   localparam logic signed [FB_COEF_W-1:0]  RST_FB_COEF_2  = 19'sd0;
   localparam logic [GAIN_W-1:0]            RST_NUM_GAIN   = 17'd102;

   typedef enum logic [3:0] {
      S_IDLE,
      S_COEF,
      S_LO,
      S_HI,
      S_NACC,
      S_NDIV,
      S_DMUL,
      S_DDIV,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      MUL_COEF,
      MUL_LO,
      MUL_HI,
      MUL_FB
   } mul_sel_type;

   typedef struct packed {
      logic [TAP_W-1:0] tap;
      mul_sel_type      mul_sel;
      logic             coef_load;
      logic             acc_load;
      logic             acc_add;
      logic             num_term;
      logic             fb_term;
      logic             done;
      logic             idle;
   } ctrl_type;

endpackage

// ----- rtl/core/fiir_if.sv -----
// Request, response and register write channels of the filter.
// Depends on fiir_pkg for field widths.
`timescale 1ns / 1ps

interface fiir_req_if import fiir_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       mode;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, mode, sample, input ready);
   modport sink   (input valid, mode, sample, output ready);
endinterface

interface fiir_rsp_if import fiir_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] filtered;

   modport source (output valid, filtered, input ready);
   modport sink   (input valid, filtered, output ready);
endinterface

interface fiir_csr_if import fiir_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/fiir_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on fiir_pkg for operand widths.
`timescale 1ns / 1ps

module fiir_mul import fiir_pkg::*; (
   input  logic                      clock,
   input  logic signed [MUL_A_W-1:0] op_a,
   input  logic signed [MUL_B_W-1:0] op_b,
   output logic signed [PROD_W-1:0]  prod_ff
);

   logic signed [PROD_W-1:0] prod_in;

   // Form the full product
   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   // Register it for the next step
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ----- rtl/core/fiir_ctrl.sv -----
// Step sequencer of the filter: walks the taps through the shared multiplier.
// Depends on fiir_pkg for states and the control struct.
`timescale 1ns / 1ps

module fiir_ctrl import fiir_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  logic     preload,
   input  logic     out_free,
   output ctrl_type ctrl
);

   state_type        state_ff, state_in;
   logic [TAP_W-1:0] tap_ff, tap_in;
   logic             last_tap;

   assign last_tap = (tap_ff == TAP_W'(TAPS - 1));

   // Next state and tap counter
   always_comb begin
      state_in = state_ff;
      tap_in   = tap_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               tap_in   = '0;
               state_in = preload ? S_DONE : S_COEF;
            end
         end
         S_COEF: state_in = S_LO;
         S_LO:   state_in = S_HI;
         S_HI:   state_in = S_NACC;
         S_NACC: state_in = S_NDIV;
         S_NDIV: begin
            if (last_tap) begin
               tap_in   = TAP_W'(1);
               state_in = S_DMUL;
            end else begin
               tap_in   = tap_ff + TAP_W'(1);
               state_in = S_COEF;
            end
         end
         S_DMUL: state_in = S_DDIV;
         S_DDIV: begin
            if (last_tap) begin
               tap_in   = '0;
               state_in = S_DONE;
            end else begin
               tap_in   = tap_ff + TAP_W'(1);
               state_in = S_DMUL;
            end
         end
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control outputs per step
   always_comb begin
      ctrl           = '0;
      ctrl.tap       = tap_ff;
      ctrl.mul_sel   = MUL_COEF;
      unique case (state_ff)
         S_IDLE: ctrl.idle = 1'b1;
         S_COEF: ctrl.mul_sel = MUL_COEF;
         S_LO: begin
            ctrl.mul_sel   = MUL_LO;
            ctrl.coef_load = 1'b1;
         end
         S_HI: begin
            ctrl.mul_sel  = MUL_HI;
            ctrl.acc_load = 1'b1;
         end
         S_NACC: ctrl.acc_add = 1'b1;
         S_NDIV: ctrl.num_term = 1'b1;
         S_DMUL: ctrl.mul_sel = MUL_FB;
         S_DDIV: ctrl.fb_term = 1'b1;
         S_DONE: ctrl.done = 1'b1;
         default: ctrl.idle = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         tap_ff   <= '0;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
      end
   end

endmodule

// ----- rtl/core/fixed_point_iir_filter_unit.sv -----
// Top level of the fixed point direct form I IIR filter.
// Depends on fiir_pkg, fiir_if, fiir_mul, fiir_ctrl and assert_macros.svh.
`timescale 1ns / 1ps

// One request at a time. A preload request goes from acceptance straight to
// the finish step that loads the result. The steps of a filter request are
// set by the single 33x19 multiplier: each feed-forward tap takes five steps
// (the coefficient-gain product, two half-sample products, an accumulate and
// a truncating divide step), each feedback tap two (one product and a divide
// step), and one finish step loads the result. A new request is taken once
// the result has been loaded into the output register, which holds it while
// the sink stalls. SCALE must be a power of two; the divide by SCALE
// truncates toward zero. Register writes are taken every cycle.
`include "assert_macros.svh"

module fixed_point_iir_filter_unit import fiir_pkg::*; (
   input logic         clock,
   input logic         reset,
   fiir_req_if.sink    req_ch,
   fiir_rsp_if.source  rsp_ch,
   fiir_csr_if.sink    csr_ch
);

   ctrl_type                    ctrl;
   logic                        accept;
   logic                        out_free;

   logic signed [NUM_COEF_W-1:0] num_coef_0_ff, num_coef_1_ff, num_coef_2_ff;
   logic signed [FB_COEF_W-1:0]  fb_coef_1_ff, fb_coef_2_ff;
   logic [GAIN_W-1:0]            num_gain_ff;

   logic                         mode_ff;
   logic signed [SAMPLE_W-1:0]   sample_ff;
   logic signed [SAMPLE_W-1:0]   x_hist_ff [HIST];
   logic signed [SAMPLE_W-1:0]   y_hist_ff [HIST];

   logic signed [NUM_COEF_W-1:0] b_sel;
   logic signed [FB_COEF_W-1:0]  fb_sel;
   logic signed [SAMPLE_W-1:0]   x_sel, y_sel;

   logic signed [MUL_A_W-1:0]    op_a;
   logic signed [MUL_B_W-1:0]    op_b;
   logic signed [PROD_W-1:0]     prod_ff;
   logic signed [ACC_W-1:0]      prod_ext;

   logic signed [MUL_A_W-1:0]    coef_ff;
   logic signed [ACC_W-1:0]      acc_ff, acc_in;
   logic signed [ACC_W-1:0]      div_src, div_bias, div_biased, div_quot;
   logic signed [SAMPLE_W-1:0]   sum_ff, sum_in;

   logic                         rsp_valid_ff;
   logic signed [SAMPLE_W-1:0]   rsp_data_ff;

   assign accept   = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   assign req_ch.ready    = ctrl.idle;
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.filtered = rsp_data_ff;
   assign csr_ch.ready    = 1'b1;

   fiir_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .preload  (req_ch.mode),
      .out_free (out_free),
      .ctrl     (ctrl)
   );

   // Register writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         num_coef_0_ff <= RST_NUM_COEF_0;
         num_coef_1_ff <= RST_NUM_COEF_1;
         num_coef_2_ff <= RST_NUM_COEF_2;
         fb_coef_1_ff  <= RST_FB_COEF_1;
         fb_coef_2_ff  <= RST_FB_COEF_2;
         num_gain_ff   <= RST_NUM_GAIN;
      end else if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.index)
            REG_NUM_COEF_0: num_coef_0_ff <= csr_ch.data[NUM_COEF_W-1:0];
            REG_NUM_COEF_1: num_coef_1_ff <= csr_ch.data[NUM_COEF_W-1:0];
            REG_NUM_COEF_2: num_coef_2_ff <= csr_ch.data[NUM_COEF_W-1:0];
            REG_FB_COEF_1:  fb_coef_1_ff  <= csr_ch.data[FB_COEF_W-1:0];
            REG_FB_COEF_2:  fb_coef_2_ff  <= csr_ch.data[FB_COEF_W-1:0];
            REG_NUM_GAIN:   num_gain_ff   <= csr_ch.data[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // Pick coefficients and history words for the current tap
   always_comb begin
      b_sel  = num_coef_0_ff;
      fb_sel = fb_coef_1_ff;
      x_sel  = sample_ff;
      y_sel  = y_hist_ff[0];
      if (int'(ctrl.tap) == 1) b_sel = num_coef_1_ff;
      if (int'(ctrl.tap) == 2) begin
         b_sel  = num_coef_2_ff;
         fb_sel = fb_coef_2_ff;
      end
      for (int k = 0; k < HIST; k++) begin
         if (int'(ctrl.tap) == k + 1) begin
            x_sel = x_hist_ff[k];
            y_sel = y_hist_ff[k];
         end
      end
   end

   // Multiplier operands per step
   always_comb begin
      unique case (ctrl.mul_sel)
         MUL_COEF: begin
            op_a = {{(MUL_A_W - GAIN_W){1'b0}}, num_gain_ff};
            op_b = {{(MUL_B_W - NUM_COEF_W){b_sel[NUM_COEF_W-1]}}, b_sel};
         end
         MUL_LO: begin
            op_a = prod_ff[MUL_A_W-1:0];
            op_b = {{(MUL_B_W - HALF_W){1'b0}}, x_sel[HALF_W-1:0]};
         end
         MUL_HI: begin
            op_a = coef_ff;
            op_b = {{(MUL_B_W - HALF_W){x_sel[SAMPLE_W-1]}}, x_sel[SAMPLE_W-1:HALF_W]};
         end
         MUL_FB: begin
            op_a = {{(MUL_A_W - SAMPLE_W){y_sel[SAMPLE_W-1]}}, y_sel};
            op_b = fb_sel;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   fiir_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (prod_ff)
   );

   assign prod_ext = {{(ACC_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   // Accumulate the two half-sample products
   always_comb begin
      acc_in = acc_ff;
      if (ctrl.acc_load) acc_in = prod_ext;
      if (ctrl.acc_add)  acc_in = acc_ff + {prod_ext[ACC_W-HALF_W-1:0], {HALF_W{1'b0}}};
   end

   // Divide by SCALE, truncating toward zero
   assign div_src    = ctrl.num_term ? acc_ff : prod_ext;
   assign div_bias   = div_src[ACC_W-1] ? ACC_W'(SCALE - 1) : '0;
   assign div_biased = div_src + div_bias;
   assign div_quot   = div_biased >>> SCALE_SHIFT;

   // Running sum, wrapping at 32 bits
   always_comb begin
      sum_in = sum_ff;
      if (accept)        sum_in = req_ch.mode ? req_ch.sample : '0;
      if (ctrl.num_term) sum_in = sum_ff + div_quot[SAMPLE_W-1:0];
      if (ctrl.fb_term)  sum_in = sum_ff - div_quot[SAMPLE_W-1:0];
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff   <= req_ch.mode;
         sample_ff <= req_ch.sample;
      end
      if (ctrl.coef_load) coef_ff <= prod_ff[MUL_A_W-1:0];
      acc_ff <= acc_in;
      sum_ff <= sum_in;
   end

   // Update histories as the result leaves
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < HIST; k++) begin
            x_hist_ff[k] <= '0;
            y_hist_ff[k] <= '0;
         end
      end else if (ctrl.done && out_free) begin
         for (int k = 0; k < HIST; k++) begin
            if (mode_ff) begin
               x_hist_ff[k] <= sample_ff;
               y_hist_ff[k] <= sample_ff;
            end else if (k == 0) begin
               x_hist_ff[k] <= sample_ff;
               y_hist_ff[k] <= sum_ff;
            end else begin
               x_hist_ff[k] <= x_hist_ff[k-1];
               y_hist_ff[k] <= y_hist_ff[k-1];
            end
         end
      end
   end

   // Output register: load on finish, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.done && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.done && out_free) rsp_data_ff <= sum_ff;
   end

   // Checks
   `ASSERT_CLK(a_tap_range, clock, reset, int'(ctrl.tap) <= TAPS - 1, "tap counter out of range")
   `ASSERT_CLK(a_preload_path, clock, reset, (accept && req_ch.mode) |=> ctrl.done, "preload did not finish directly")
   `ASSERT_CLK(a_rsp_from_done, clock, reset, $rose(rsp_ch.valid) |-> $past(ctrl.done), "result loaded outside finish step")

endmodule
